@@ design/spr_anim_pkg.sv @@
// Shared types, constants and codes for the sprite animation sequencer.
`timescale 1ns / 1ps
package spr_anim_pkg;

    localparam int MAX_ANIMATIONS = 16;
    localparam int QUEUE_DEPTH    = 8;
    localparam int ANIM_W   = $clog2(MAX_ANIMATIONS);
    localparam int COUNT_W  = $clog2(MAX_ANIMATIONS + 1);
    localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int FRAME_W  = 10;
    localparam int PIX_W    = 16;
    localparam int DIM_W    = 9;
    localparam int SHEET_W  = 7;
    localparam int LOOP_W   = 8;
    localparam int STEP_W   = $clog2(FRAME_W);
    localparam int CFG_IDX_W = 2;

    // Item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PLAY   = 2'd1;
    localparam logic [1:0] KIND_QUEUE  = 2'd2;
    localparam logic [1:0] KIND_DEFINE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_OFF     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_ROWS    = 2'd3;

    // Ticks per frame advance, minus one
    localparam logic [1:0] TICK_LAST = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ANIM_W-1:0]  anim_id;
        logic [LOOP_W-1:0]  loop_count;
        logic [FRAME_W-1:0] first_frame;
        logic [FRAME_W-1:0] last_frame;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0]   src_x;
        logic [PIX_W-1:0]   src_y;
        logic [FRAME_W-1:0] frame_number;
        logic [ANIM_W-1:0]  current_anim;
        logic               frame_changed;
        logic [1:0]         status;
    } t_result;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic div_init;
        logic div_step;
        logic mul;
        logic emit;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_DINIT,
        S_DIV,
        S_MUL,
        S_EMIT
    } t_state;

endpackage

@@ design/sprite_animation_sequencer_top.sv @@
// Top level of the sprite animation sequencer: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Items enter on i_item and are taken at a rising edge with start high and
//   busy low. Kinds: tick, play, queue, define. Every item yields exactly one
//   result on o_result, marked by o_valid for a single cycle; the receiver
//   must take it then, there is no stall path.
//   After acceptance busy stays high through update, first-frame load,
//   divider setup, the bit-serial frame/columns divider, one scaling
//   multiply and the output state; the registered result strobe follows.
//   A new item may be accepted in the cycle the previous result is shown.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data
//   write frame width, frame height, sheet columns and sheet rows. Ready is
//   always high; write only while no item is in flight.
//   Reset (i_rst_n low, synchronous): registers return to 32/32/8/8, the
//   frame, animation, tick phase, table count and queue are cleared. The
//   table and queue contents are not cleared; only written entries are read.
module sprite_animation_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  spr_anim_pkg::t_item                 i_item,
    output spr_anim_pkg::t_result               o_result,
    output logic                                o_valid,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spr_anim_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spr_anim_pkg::DIM_W-1:0]      i_cfg_data
);

    spr_anim_pkg::t_cmd cmd;

    // config writes never wait
    assign o_cfg_ready = 1'b1;

    spr_anim_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    spr_anim_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result),
        .o_valid     (o_valid)
    );

endmodule

@@ design/spr_anim_ctrl.sv @@
// Sequencing state machine: steps each item through update, divide, scale, emit.
`timescale 1ns / 1ps
module spr_anim_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output spr_anim_pkg::t_cmd   o_cmd
);

    spr_anim_pkg::t_state r_state, n_state;
    logic [spr_anim_pkg::STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spr_anim_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            spr_anim_pkg::S_IDLE: begin
                if (start) n_state = spr_anim_pkg::S_EXEC;
            end
            spr_anim_pkg::S_EXEC:  n_state = spr_anim_pkg::S_LOAD;
            spr_anim_pkg::S_LOAD:  n_state = spr_anim_pkg::S_DINIT;
            spr_anim_pkg::S_DINIT: begin
                n_state = spr_anim_pkg::S_DIV;
                n_step  = '0;
            end
            spr_anim_pkg::S_DIV: begin
                if (r_step == spr_anim_pkg::STEP_W'(spr_anim_pkg::FRAME_W - 1)) begin
                    n_state = spr_anim_pkg::S_MUL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            spr_anim_pkg::S_MUL:  n_state = spr_anim_pkg::S_EMIT;
            spr_anim_pkg::S_EMIT: n_state = spr_anim_pkg::S_IDLE;
            default:              n_state = spr_anim_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            spr_anim_pkg::S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            spr_anim_pkg::S_EXEC:  o_cmd.exec     = 1'b1;
            spr_anim_pkg::S_LOAD:  o_cmd.load     = 1'b1;
            spr_anim_pkg::S_DINIT: o_cmd.div_init = 1'b1;
            spr_anim_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            spr_anim_pkg::S_MUL:   o_cmd.mul      = 1'b1;
            spr_anim_pkg::S_EMIT:  o_cmd.emit     = 1'b1;
            default:               busy           = 1'b1;
        endcase
    end

endmodule

@@ design/spr_anim_dp.sv @@
// Datapath: config registers, animation table, loop queue, divider and scaler.
`timescale 1ns / 1ps
module spr_anim_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spr_anim_pkg::t_cmd                  i_cmd,
    input  spr_anim_pkg::t_item                 i_item,
    input  logic                                i_cfg_we,
    input  logic [spr_anim_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spr_anim_pkg::DIM_W-1:0]      i_cfg_data,
    output spr_anim_pkg::t_result               o_result,
    output logic                                o_valid
);

    localparam int AW = spr_anim_pkg::ANIM_W;
    localparam int CW = spr_anim_pkg::COUNT_W;
    localparam int QW = spr_anim_pkg::QIDX_W;
    localparam int FW = spr_anim_pkg::FILL_W;
    localparam int NW = spr_anim_pkg::FRAME_W;
    localparam int SW = spr_anim_pkg::SHEET_W;
    localparam int DW = spr_anim_pkg::DIM_W;
    localparam int PW = spr_anim_pkg::PIX_W;
    localparam int LW = spr_anim_pkg::LOOP_W;

    // configuration
    logic [DW-1:0] r_frame_width, r_frame_height;
    logic [SW-1:0] r_sheet_cols, r_sheet_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DW'(32);
            r_frame_height <= DW'(32);
            r_sheet_cols   <= SW'(8);
            r_sheet_rows   <= SW'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spr_anim_pkg::CFG_FRAME_WIDTH:   r_frame_width  <= i_cfg_data;
                spr_anim_pkg::CFG_FRAME_HEIGHT:  r_frame_height <= i_cfg_data;
                spr_anim_pkg::CFG_SHEET_COLUMNS: r_sheet_cols   <= i_cfg_data[SW-1:0];
                spr_anim_pkg::CFG_SHEET_ROWS:    r_sheet_rows   <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // item and sequencing state
    spr_anim_pkg::t_item r_item;
    logic [1:0]    r_tick_phase, n_tick_phase;
    logic [NW-1:0] r_frame_now,  n_frame_now;
    logic [AW-1:0] r_anim_now,   n_anim_now;
    logic [CW-1:0] r_anim_count, n_anim_count;
    logic [QW-1:0] r_q_head,     n_q_head;
    logic [FW-1:0] r_q_fill,     n_q_fill;
    logic          r_wrap,       n_wrap;
    logic          r_changed,    n_changed;
    logic [1:0]    r_status,     n_status;

    logic [NW-1:0] r_tab_first [spr_anim_pkg::MAX_ANIMATIONS];
    logic [NW-1:0] r_tab_last  [spr_anim_pkg::MAX_ANIMATIONS];
    logic [AW-1:0] r_q_anim    [spr_anim_pkg::QUEUE_DEPTH];
    logic [LW-1:0] r_q_loops   [spr_anim_pkg::QUEUE_DEPTH];

    // undefined animations read as frames 0..0
    logic          cur_defined;
    logic [NW-1:0] cur_first, cur_last;
    logic [NW:0]   next_frame;
    logic [QW-1:0] head_inc, q_slot;
    logic [LW-1:0] head_loops;

    // table / queue write controls
    logic          tab_we, q_we, q_dec;
    logic [QW-1:0] q_waddr;

    assign cur_defined = {{(CW-AW){1'b0}}, r_anim_now} < r_anim_count;
    assign cur_first   = cur_defined ? r_tab_first[r_anim_now] : '0;
    assign cur_last    = cur_defined ? r_tab_last[r_anim_now]  : '0;
    assign next_frame  = {1'b0, r_frame_now} + 1'b1;
    assign head_inc    = r_q_head + 1'b1;
    assign q_slot      = r_q_head + r_q_fill[QW-1:0];
    assign head_loops  = r_q_loops[r_q_head];

    always_comb begin
        n_tick_phase = r_tick_phase;
        n_frame_now  = r_frame_now;
        n_anim_now   = r_anim_now;
        n_anim_count = r_anim_count;
        n_q_head     = r_q_head;
        n_q_fill     = r_q_fill;
        n_wrap       = r_wrap;
        n_changed    = r_changed;
        n_status     = r_status;
        tab_we       = 1'b0;
        q_we         = 1'b0;
        q_dec        = 1'b0;
        q_waddr      = q_slot;
        if (i_cmd.exec) begin
            n_wrap    = 1'b0;
            n_changed = 1'b0;
            n_status  = spr_anim_pkg::ST_OK;
            case (r_item.kind)
                spr_anim_pkg::KIND_TICK: begin
                    if (r_tick_phase < spr_anim_pkg::TICK_LAST) begin
                        n_tick_phase = r_tick_phase + 1'b1;
                    end else begin
                        n_tick_phase = '0;
                        n_changed    = 1'b1;
                        if (next_frame > {1'b0, cur_last}) begin
                            n_wrap = 1'b1;
                            if (r_q_fill != '0) begin
                                // zero loop count plays forever
                                if (head_loops != '0) begin
                                    q_dec = 1'b1;
                                    if (head_loops == LW'(1)) begin
                                        n_q_head = head_inc;
                                        n_q_fill = r_q_fill - 1'b1;
                                    end
                                end
                                if (n_q_fill != '0) n_anim_now = r_q_anim[n_q_head];
                            end
                        end else begin
                            n_frame_now = next_frame[NW-1:0];
                        end
                    end
                end
                spr_anim_pkg::KIND_PLAY: begin
                    if ({{(CW-AW){1'b0}}, r_item.anim_id} >= r_anim_count) begin
                        n_status = spr_anim_pkg::ST_INVALID;
                    end else begin
                        n_q_head   = '0;
                        n_q_fill   = FW'(1);
                        q_we       = 1'b1;
                        q_waddr    = '0;
                        n_anim_now = r_item.anim_id;
                        n_wrap     = 1'b1;
                        n_changed  = 1'b1;
                    end
                end
                spr_anim_pkg::KIND_QUEUE: begin
                    if (r_q_fill >= FW'(spr_anim_pkg::QUEUE_DEPTH)) begin
                        n_status = spr_anim_pkg::ST_FULL;
                    end else begin
                        q_we     = 1'b1;
                        n_q_fill = r_q_fill + 1'b1;
                    end
                end
                spr_anim_pkg::KIND_DEFINE: begin
                    if (r_anim_count >= CW'(spr_anim_pkg::MAX_ANIMATIONS)) begin
                        n_status = spr_anim_pkg::ST_FULL;
                    end else begin
                        tab_we       = 1'b1;
                        n_anim_count = r_anim_count + 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // jump to the first frame of the (possibly new) current animation
        if (i_cmd.load && r_wrap) n_frame_now = cur_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_phase <= '0;
            r_frame_now  <= '0;
            r_anim_now   <= '0;
            r_anim_count <= '0;
            r_q_head     <= '0;
            r_q_fill     <= '0;
            r_wrap       <= 1'b0;
            r_changed    <= 1'b0;
            r_status     <= spr_anim_pkg::ST_OK;
        end else begin
            r_tick_phase <= n_tick_phase;
            r_frame_now  <= n_frame_now;
            r_anim_now   <= n_anim_now;
            r_anim_count <= n_anim_count;
            r_q_head     <= n_q_head;
            r_q_fill     <= n_q_fill;
            r_wrap       <= n_wrap;
            r_changed    <= n_changed;
            r_status     <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (tab_we) begin
            r_tab_first[r_anim_count[AW-1:0]] <= r_item.first_frame;
            r_tab_last[r_anim_count[AW-1:0]]  <= r_item.last_frame;
        end
        if (q_we) begin
            r_q_anim[q_waddr]  <= r_item.anim_id;
            r_q_loops[q_waddr] <= r_item.loop_count;
        end else if (q_dec) begin
            r_q_loops[r_q_head] <= head_loops - 1'b1;
        end
    end

    // restoring divide of frame by columns, one quotient bit per cycle
    logic [SW-1:0] cols_eff;
    logic [NW-1:0] r_quo;
    logic [SW-1:0] r_rem;
    logic [SW:0]   div_trial;
    logic          div_ge;

    assign cols_eff  = (r_sheet_cols == '0) ? SW'(1) : r_sheet_cols;
    assign div_trial = {r_rem, r_quo[NW-1]};
    assign div_ge    = div_trial >= {1'b0, cols_eff};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= r_frame_now;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[NW-2:0], div_ge};
            if (div_ge) begin
                r_rem <= SW'(div_trial - {1'b0, cols_eff});
            end else begin
                r_rem <= div_trial[SW-1:0];
            end
        end
    end

    // scale column and inverted row to pixels
    logic [PW-1:0] r_sx, r_sy;
    logic          r_off;
    logic          row_off;
    logic [SW-1:0] inv_row;

    assign row_off = r_quo >= {{(NW-SW){1'b0}}, r_sheet_rows};
    assign inv_row = r_sheet_rows - SW'(1) - r_quo[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_sx  <= {{(PW-SW){1'b0}}, r_rem} * {{(PW-DW){1'b0}}, r_frame_width};
            r_off <= row_off;
            if (row_off) begin
                r_sy <= '0;
            end else begin
                r_sy <= {{(PW-SW){1'b0}}, inv_row} * {{(PW-DW){1'b0}}, r_frame_height};
            end
        end
    end

    // output register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result.src_x         <= r_sx;
            o_result.src_y         <= r_sy;
            o_result.frame_number  <= r_frame_now;
            o_result.current_anim  <= r_anim_now;
            o_result.frame_changed <= r_changed;
            o_result.status        <= (r_changed && r_off) ? spr_anim_pkg::ST_OFF : r_status;
        end
    end

endmodule
